[rtl/core/lbs_pkg.sv]
// Package: constants, types and arithmetic helpers for the skinning unit.
`default_nettype none
package lbs_pkg;
	localparam int MAX_JOINTS      = 64;
	localparam int COORD_BITS      = 32;
	localparam int WORDS_PER_JOINT = 12;
	localparam int ACC_BITS        = 48;
	localparam int WORD_BITS       = 32;
	localparam int MEM_DEPTH       = MAX_JOINTS * WORDS_PER_JOINT;
	localparam int MEM_AW          = $clog2(MEM_DEPTH);
	localparam int JOINT_BITS      = 6;
	localparam int MWORD_BITS      = 4;
	localparam int WEIGHT_BITS     = 17;
	localparam int TERM_BITS       = 52;
	localparam int SUM_BITS        = TERM_BITS + 3;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_INFL   = 2'd1,
		ACT_EMPTY  = 2'd2,
		ACT_UNUSED = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_SCALE,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z;
	} vertex_t;

	typedef struct packed {
		logic [1:0]                    action;
		logic [JOINT_BITS-1:0]         joint_index;
		logic [MWORD_BITS-1:0]         matrix_word;
		logic signed [WORD_BITS-1:0]   matrix_value;
		logic signed [WORD_BITS-1:0]   rest_pos_x, rest_pos_y, rest_pos_z;
		logic signed [WORD_BITS-1:0]   rest_nrm_x, rest_nrm_y, rest_nrm_z;
		logic [WEIGHT_BITS-1:0]        weight;
		logic                          last_influence;
	} item_t;

	// saturate a wide sum to the signed accumulator range
	function automatic logic signed [ACC_BITS-1:0] sat_acc(
		input logic signed [SUM_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] hi;
		logic signed [ACC_BITS-1:0] lo;
		hi = {1'b0, {(ACC_BITS-1){1'b1}}};
		lo = {1'b1, {(ACC_BITS-1){1'b0}}};
		if (v[SUM_BITS-1:ACC_BITS-1] != {(SUM_BITS-ACC_BITS+1){v[SUM_BITS-1]}})
			return v[SUM_BITS-1] ? lo : hi;
		return v[ACC_BITS-1:0];
	endfunction

	function automatic logic signed [WORD_BITS-1:0] sat_out(
		input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] hi;
		logic signed [ACC_BITS-1:0] lo;
		hi = (ACC_BITS'(1) <<< (COORD_BITS-1)) - ACC_BITS'(1);
		lo = -hi - ACC_BITS'(1);
		if (v > hi) return WORD_BITS'(hi);
		if (v < lo) return WORD_BITS'(lo);
		return WORD_BITS'(v);
	endfunction
endpackage
`default_nettype wire

[rtl/core/lbs_stream_if.sv]
// Interfaces: valid/ready channels for items and results.
`default_nettype none
interface lbs_item_if import lbs_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface

interface lbs_vertex_if import lbs_pkg::*; ();
	logic    valid;
	logic    ready;
	vertex_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input data, input ready);
endinterface
`default_nettype wire

[rtl/core/lbs_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

[rtl/core/linear_blend_skinning_unit.sv]
// Linear blend skinning unit: top level with sequencer and shared multiplier.
//
// Channels: item_in (sink) carries matrix writes, influences and empty-vertex
// items; vert_out (source) carries skinned vertices. A transfer happens when
// valid and ready are both high at a rising clock edge.
// A matrix write or an unused action code leaves the sequencer idle; writes can
// follow back to back. An influence walks the 3x4 matrix one word per step
// through one shared 32x32 multiplier and one weight multiplier: per matrix
// row three columns of read, position product and normal product, the
// translation read and add, then weighting and accumulation of position and
// normal. The single matrix memory port and the shared multiplier keep the
// sequencer busy, so no new item is taken until the influence is done.
// An influence flagged last, and an empty-vertex item with its sums zeroed,
// then pass through the output state; the next item is taken only once the
// result is loaded into the result register.
// The result register parts the two sides: a new item may be taken while a
// result waits, and the next result holds in the output cycle until taken.
// Reset (arst_n low) clears the sequencer and accumulators; the matrix memory
// is not cleared and must be written before use.
// A stalled receiver simply holds the result; no item is lost.
`default_nettype none
module linear_blend_skinning_unit import lbs_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	lbs_item_if.sink       item_in,
	lbs_vertex_if.source   vert_out
);
	state_t state_q, state_d;
	item_t  it_q;
	logic [1:0] row_q;     // matrix row
	logic [1:0] col_q;     // 0..2 columns, 3 = translation
	logic       half_q;    // 0 = position, 1 = normal product
	logic       wsel_q;    // weighting: 0 position, 1 normal
	logic signed [WORD_BITS-1:0] m_q;
	logic signed [TERM_BITS-1:0] tp_q, tn_q;
	logic signed [ACC_BITS-1:0]  psum_q [3];
	logic signed [ACC_BITS-1:0]  nsum_q [3];
	logic signed [TERM_BITS+1:0] scaled_q;
	vertex_t out_q;
	logic    out_valid_q;

	logic                 mem_we;
	logic [MEM_AW-1:0]    mem_addr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic [MEM_AW-1:0]    joint_base;
	logic                 in_xfer;
	logic                 wr_ok;
	logic                 out_load;

	assign joint_base = MEM_AW'(it_q.joint_index) * MEM_AW'(WORDS_PER_JOINT);
	assign in_xfer = item_in.valid && item_in.ready;
	assign wr_ok = (32'(item_in.data.joint_index) < MAX_JOINTS)
		&& (item_in.data.matrix_word < MWORD_BITS'(WORDS_PER_JOINT));

	always_comb begin
		mem_we = in_xfer && item_in.data.action == ACT_WRITE && wr_ok;
		if (state_q == ST_IDLE)
			mem_addr = MEM_AW'(item_in.data.joint_index) * MEM_AW'(WORDS_PER_JOINT)
				+ MEM_AW'(item_in.data.matrix_word);
		else if (col_q == 2'd3)
			mem_addr = joint_base + MEM_AW'(9) + MEM_AW'(row_q);
		else
			mem_addr = joint_base + MEM_AW'(row_q) * MEM_AW'(3) + MEM_AW'(col_q);
	end

	lbs_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_DEPTH)) u_mat (
		.clk(clk), .we(mem_we), .addr(mem_addr),
		.wdata(item_in.data.matrix_value), .rdata(mem_rdata)
	);

	// read data lands in the cycle after ST_READ and holds while the address holds
	assign m_q = mem_rdata;

	// shared multiplier operands
	logic signed [WORD_BITS-1:0]  vec_op;
	logic signed [2*WORD_BITS-1:0] prod;
	logic signed [TERM_BITS-1:0]  prod_sh;
	always_comb begin
		unique case (col_q)
			2'd0:    vec_op = half_q ? it_q.rest_nrm_x : it_q.rest_pos_x;
			2'd1:    vec_op = half_q ? it_q.rest_nrm_y : it_q.rest_pos_y;
			default: vec_op = half_q ? it_q.rest_nrm_z : it_q.rest_pos_z;
		endcase
		prod    = m_q * vec_op;
		prod_sh = TERM_BITS'(prod >>> 16);
	end

	// weight scaling: floor(t*w/65536) = hi*w + ((lo*w)>>16)
	logic signed [TERM_BITS-1:0]   t_sel;
	logic signed [TERM_BITS-17:0]  t_hi;
	logic [15:0]                   t_lo;
	logic signed [TERM_BITS+1:0]   sc_full;
	assign t_sel = wsel_q ? tn_q : tp_q;
	assign t_hi  = t_sel[TERM_BITS-1:16];
	assign t_lo  = t_sel[15:0];
	assign sc_full = (TERM_BITS+2)'(t_hi)
		* (TERM_BITS+2)'($signed({1'b0, it_q.weight}))
		+ (TERM_BITS+2)'(({16'd0, t_lo} * 33'(it_q.weight)) >> 16);

	logic do_acc_valid;
	assign do_acc_valid = 32'(it_q.joint_index) < MAX_JOINTS;

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || vert_out.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_xfer) begin
				if (item_in.data.action == ACT_EMPTY) state_d = ST_OUT;
				else if (item_in.data.action == ACT_INFL) state_d = ST_READ;
			end
			ST_READ:  state_d = ST_MUL;
			ST_MUL:   begin
				if (col_q == 2'd3) state_d = ST_SCALE;
				else if (half_q) state_d = ST_READ;
			end
			ST_SCALE: state_d = ST_ACC;
			ST_ACC:   begin
				if (!wsel_q) state_d = ST_SCALE;
				else if (row_q != 2'd2) state_d = ST_READ;
				else if (it_q.last_influence) state_d = ST_OUT;
				else state_d = ST_IDLE;
			end
			ST_OUT:   if (!out_valid_q || vert_out.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_in.ready = (state_q == ST_IDLE);
		vert_out.valid = out_valid_q;
		vert_out.data  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (vert_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q <= '0; col_q <= '0; half_q <= 1'b0; wsel_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				psum_q[i] <= '0;
				nsum_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: if (in_xfer) begin
					it_q <= item_in.data;
					row_q <= '0; col_q <= '0; half_q <= 1'b0; wsel_q <= 1'b0;
					if (item_in.data.action == ACT_EMPTY)
						for (int i = 0; i < 3; i++) begin
							psum_q[i] <= '0;
							nsum_q[i] <= '0;
						end
				end
				ST_READ: begin
					half_q <= 1'b0;
					if (col_q == 2'd0) begin
						tp_q <= '0;
						tn_q <= '0;
					end
				end
				ST_MUL: begin
					if (col_q == 2'd3) begin
						tp_q <= tp_q + TERM_BITS'(m_q);
						col_q <= '0;
					end else if (!half_q) begin
						tp_q <= tp_q + prod_sh;
						half_q <= 1'b1;
					end else begin
						tn_q <= tn_q + prod_sh;
						col_q <= col_q + 2'd1;
					end
				end
				ST_SCALE: scaled_q <= sc_full;
				ST_ACC: begin
					if (do_acc_valid) begin
						if (!wsel_q) psum_q[row_q] <= sat_acc(
							SUM_BITS'(psum_q[row_q]) + SUM_BITS'(scaled_q));
						else nsum_q[row_q] <= sat_acc(
							SUM_BITS'(nsum_q[row_q]) + SUM_BITS'(scaled_q));
					end
					wsel_q <= !wsel_q;
					if (wsel_q) row_q <= row_q + 2'd1;
				end
				ST_OUT: if (!out_valid_q || vert_out.ready) begin
					out_q.pos_x <= sat_out(psum_q[0]);
					out_q.pos_y <= sat_out(psum_q[1]);
					out_q.pos_z <= sat_out(psum_q[2]);
					out_q.nrm_x <= sat_out(nsum_q[0]);
					out_q.nrm_y <= sat_out(nsum_q[1]);
					out_q.nrm_z <= sat_out(nsum_q[2]);
					for (int i = 0; i < 3; i++) begin
						psum_q[i] <= '0;
						nsum_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !vert_out.ready |=> out_valid_q && $stable(out_q))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> !item_in.ready) else $error("accepted while busy");
endmodule
`default_nettype wire
